@@ rtl/pst_pkg.sv @@
package pst_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CODE_W   = 16;
    localparam int PRICE_W  = 20;
    localparam int CAT_W    = 8;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic               action;
        logic [CODE_W-1:0]  item_code;
        logic [PRICE_W-1:0] item_price;
        logic [CAT_W-1:0]   item_category;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [CODE_W-1:0]  out_code;
        logic [PRICE_W-1:0] out_price;
        logic [CAT_W-1:0]   out_category;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [PRICE_W-1:0] price;
        logic [CAT_W-1:0]   category;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_REM_RD,
        S_REM_CMP,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic ins_cmp;
        logic ins_put;
        logic rem_cmp;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic remove_req;
        logic full;
        logic empty;
        logic at_end;
        logic ins_last;
        logic greater;
    } t_sts;

endpackage

@@ rtl/pst_ctrl.sv @@
module pst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pst_pkg::t_sts i_sts,
    output pst_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import pst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    priority if (i_sts.remove_req) begin
                        n_state = S_REM_RD;
                    end else if (i_sts.full) begin
                        n_state = S_DONE;
                    end else if (i_sts.empty) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_INS_CMP;
            end
            S_INS_CMP: begin
                // Larger entries move up one rank; the first one not larger stops the walk.
                o_cmd.ins_cmp = 1'b1;
                if (i_sts.greater && !i_sts.ins_last) begin
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                o_cmd.ins_put = 1'b1;
                n_state       = S_DONE;
            end
            S_REM_RD: begin
                if (i_sts.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                o_cmd.rem_cmp = 1'b1;
                n_state       = S_REM_RD;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("controller did not return to idle after a result");

    a_start_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state != S_IDLE)
        else $error("accepted transfer did not start an operation");

    a_put_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_PUT |=> r_state == S_DONE)
        else $error("insert write was not followed by a result");

endmodule

@@ rtl/pst_dp.sv @@
module pst_dp #(
    parameter int CAPACITY = pst_pkg::CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pst_pkg::t_item   i_item,
    input  pst_pkg::t_cmd    i_cmd,
    output pst_pkg::t_sts    o_sts,
    output pst_pkg::t_result o_result,
    output logic             o_valid
);
    import pst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_entry        mem [CAPACITY];
    t_entry        r_rd;
    t_item         r_item;
    t_entry        r_taken;
    t_status       r_st;
    logic          r_found;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_pos;
    t_result       r_result;
    logic          r_valid;

    logic          hit;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    t_entry        wr_data;
    t_entry        new_entry;

    assign new_entry = '{code: r_item.item_code, price: r_item.item_price,
                         category: r_item.item_category};

    assign hit = !r_found && (r_rd.code == r_item.item_code);

    // Insert walks downward from the top reading rank idx-1; remove walks upward reading rank idx.
    assign rd_addr = (r_item.action == ACT_REMOVE) ? r_idx[AW-1:0]
                                                   : AW'(r_idx - CW'(1));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_rd;
        if (i_cmd.ins_put) begin
            wr_en   = 1'b1;
            wr_data = new_entry;
        end else if (i_cmd.ins_cmp) begin
            wr_en = o_sts.greater;
        end else if (i_cmd.rem_cmp) begin
            wr_en   = r_found;
            wr_addr = AW'(r_idx - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        unique case (r_st)
            ST_INSERTED:  n_count = r_count + CW'(1);
            ST_REMOVED:   n_count = r_count - CW'(1);
            ST_FULL,
            ST_NOT_FOUND: n_count = r_count;
            default:      n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_item  <= i_item;
                r_found <= 1'b0;
                r_pos   <= '0;
                if (i_item.action == ACT_REMOVE) begin
                    r_idx <= '0;
                    r_st  <= ST_NOT_FOUND;
                end else begin
                    r_idx <= r_count;
                    r_st  <= o_sts.full ? ST_FULL : ST_INSERTED;
                end
            end
            if (i_cmd.ins_cmp && o_sts.greater) begin
                r_idx <= r_idx - CW'(1);
            end
            if (i_cmd.ins_put) begin
                r_pos <= r_idx[AW-1:0];
            end
            if (i_cmd.rem_cmp) begin
                r_idx <= r_idx + CW'(1);
                if (hit) begin
                    r_found <= 1'b1;
                    r_taken <= r_rd;
                    r_pos   <= r_idx[AW-1:0];
                    r_st    <= ST_REMOVED;
                end
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.status      <= r_st;
            r_result.slot        <= SLOT_W'(r_pos);
            r_result.entry_count <= COUNT_W'(n_count);
            unique case (r_st)
                ST_REMOVED: begin
                    r_result.out_code     <= r_taken.code;
                    r_result.out_price    <= r_taken.price;
                    r_result.out_category <= r_taken.category;
                end
                ST_NOT_FOUND: begin
                    r_result.out_code     <= r_item.item_code;
                    r_result.out_price    <= '0;
                    r_result.out_category <= '0;
                end
                ST_INSERTED,
                ST_FULL: begin
                    r_result.out_code     <= r_item.item_code;
                    r_result.out_price    <= r_item.item_price;
                    r_result.out_category <= r_item.item_category;
                end
                default: begin
                    r_result.out_code     <= r_item.item_code;
                    r_result.out_price    <= r_item.item_price;
                    r_result.out_category <= r_item.item_category;
                end
            endcase
        end
    end

    assign o_sts.remove_req = (i_item.action == ACT_REMOVE);
    assign o_sts.full       = (r_count == CW'(CAPACITY));
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.at_end     = (r_idx == r_count);
    assign o_sts.ins_last   = (r_idx == CW'(1));
    assign o_sts.greater    = (r_rd.price > r_item.item_price);

    assign o_result = r_result;
    assign o_valid  = r_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for more than one cycle");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rem_cmp && r_found) |-> r_idx != '0)
        else $error("remove shift would write below rank zero");

endmodule

@@ rtl/price_sorted_table.sv @@
// Sorted price table: holds up to CAPACITY entries (code, price, category)
// in ascending order of price, with equal prices kept in arrival order.
// Input channel: drive i_item and raise start; the transfer happens at a
// rising edge where start is high and busy is low. Action 0 inserts the
// entry after all entries of equal or lower price; action 1 removes the
// lowest-ranked entry with a matching code and reports its fields.
// Result channel: o_valid is high for exactly one cycle with o_result; the
// receiver cannot hold results off, so it must take each one as it comes.
// Storage: entries live in a single-port-write, registered-read memory that
// is walked one rank at a time, with a read step and a compare step per
// rank. An insert walks down from the top to its rank, a remove walks up
// through every entry, and an insert on a full table is refused without
// a walk. busy falls on the cycle the strobe rises, so the next transfer
// can overlap the result.
// Reset (i_rst_n low at a clock edge) empties the table and clears the
// strobe; no memory clearing pass is needed.
module price_sorted_table #(
    parameter int CAPACITY = pst_pkg::CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  pst_pkg::t_item   i_item,
    output logic             o_valid,
    output pst_pkg::t_result o_result
);
    import pst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule
